// ----- design/bcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bcf_pkg;

	localparam int COORD_W = 16;
	localparam int SEG_W   = 6;
	localparam int W_W     = 49;   // bernstein weight, up to 2^48
	localparam int SQ_W    = 33;   // u*u or t*t, up to 2^32
	localparam int MA_W    = 33;
	localparam int MB_W    = 17;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int ACC_W   = 64;
	localparam int HI_LSB  = 33;   // weights are fed to the multiplier in two slices

	localparam logic [COORD_W-1:0] BIAS = 16'h8000;
	localparam logic [4:0] DIV_TOP = 5'd17;   // dividend is 2^17
	localparam logic [ACC_W-1:0] RND_QUAD  = 64'h0000_0000_8000_0000;
	localparam logic [ACC_W-1:0] RND_CUBIC = 64'h0000_8000_0000_0000;

	localparam logic KIND_WGT = 1'b0;
	localparam logic KIND_ACC = 1'b1;

	localparam logic [2:0] DST_W0  = 3'd0;
	localparam logic [2:0] DST_W1  = 3'd1;
	localparam logic [2:0] DST_W2  = 3'd2;
	localparam logic [2:0] DST_W3  = 3'd3;
	localparam logic [2:0] DST_SQU = 3'd4;
	localparam logic [2:0] DST_SQT = 3'd5;

	localparam logic [1:0] SC_X1 = 2'd0;
	localparam logic [1:0] SC_X2 = 2'd1;
	localparam logic [1:0] SC_X3 = 2'd2;

	typedef struct packed {
		logic                      curve_degree;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] ctrl1_x;
		logic signed [COORD_W-1:0] ctrl1_y;
		logic signed [COORD_W-1:0] ctrl2_x;
		logic signed [COORD_W-1:0] ctrl2_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [SEG_W-1:0]          segments;
	} curve_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [2:0] dest;
		logic [1:0] scale;
		logic       hi;
		logic       first;
		logic       last;
		logic       coord;
		logic       cubic;
	} mac_op_t;

	typedef struct packed {
		logic           valid;
		logic [2:0]     dest;
		logic [W_W-1:0] value;
	} wgt_wr_t;

	typedef struct packed {
		logic               valid;
		logic               coord;
		logic [COORD_W-1:0] value;
	} res_wr_t;

endpackage

`default_nettype wire

// ----- design/bcf_curve_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bcf_curve_if import bcf_pkg::*; ();
	logic   valid;
	logic   ready;
	curve_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/bcf_point_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bcf_point_if import bcf_pkg::*; ();
	logic   valid;
	logic   ready;
	point_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/bcf_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcf_mac import bcf_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mac_op_t         op,
	input  wire logic [MA_W-1:0] a,
	input  wire logic [MB_W-1:0] b,
	output      wgt_wr_t         wgt_wr,
	output      res_wr_t         res_wr
);

	mac_op_t             op_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [ACC_W-1:0]    acc_q;
	logic [PROD_W+1:0]   scaled;
	logic [ACC_W-1:0]    term;
	logic [ACC_W-1:0]    base;
	logic [ACC_W-1:0]    sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	always_comb begin
		unique case (op_s1.scale)
			SC_X2:   scaled = {1'b0, prod_s1, 1'b0};
			SC_X3:   scaled = {2'b00, prod_s1} + {1'b0, prod_s1, 1'b0};
			default: scaled = {2'b00, prod_s1};
		endcase
	end

	// high weight slice carries weight bits 48:33, so its product is shifted back up
	assign term = op_s1.hi ? {prod_s1[ACC_W-HI_LSB-1:0], {HI_LSB{1'b0}}}
		: {{(ACC_W-PROD_W){1'b0}}, prod_s1};
	assign base = op_s1.first ? (op_s1.cubic ? RND_CUBIC : RND_QUAD) : acc_q;
	assign sum  = base + term;

	always_ff @(posedge clk) begin
		if (op_s1.valid && op_s1.kind == KIND_ACC) begin
			acc_q <= sum;
		end
	end

	assign wgt_wr.valid = op_s1.valid && op_s1.kind == KIND_WGT;
	assign wgt_wr.dest  = op_s1.dest;
	assign wgt_wr.value = scaled[W_W-1:0];

	assign res_wr.valid = op_s1.valid && op_s1.kind == KIND_ACC && op_s1.last;
	assign res_wr.coord = op_s1.coord;
	assign res_wr.value = op_s1.cubic ? sum[63:48] : sum[47:32];

endmodule

`default_nettype wire

// ----- design/bezier_curve_flattener.sv -----
// channel  dir  handshake     payload
// curve    in   valid/ready   curve_t: degree, start, ctrl1, ctrl2, end, segments
// point    out  valid/ready   point_t: point_x, point_y, last_point
//
// one curve of n segments starts with a divide for the t step, then for each
// point runs the weight products and two coordinate sums on one shared 33x17
// multiplier plus a drain state and an output load state. curve.ready is
// high only when idle. reset clears the sequencer and the output valid. a
// stalled point output holds the sequencer until the point is taken.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_flattener import bcf_pkg::*; #(
	parameter int MAX_SEGMENTS = 63,
	parameter int COORD_WIDTH  = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bcf_curve_if.sink   curve,
	bcf_point_if.source point
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_WGT   = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_LAST  = 3'd6;

	localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);
	localparam longint SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam longint SAT_LO = -SAT_HI - 64'sd1;

	function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] biased);
		logic signed [COORD_W-1:0] v;
		longint                    w;
		v = $signed(biased ^ BIAS);
		w = longint'(v);
		if (w > SAT_HI) w = SAT_HI;
		if (w < SAT_LO) w = SAT_LO;
		return COORD_W'(w);
	endfunction

	logic [2:0]         state_q;
	logic               cubic_q;
	logic [SEG_W-1:0]   n_q;
	logic [SEG_W:0]     d_q;
	logic [SEG_W-1:0]   idx_q;
	logic [4:0]         div_cnt_q;
	logic [SEG_W:0]     rem_q;
	logic [17:0]        quo_q;
	logic [16:0]        tq_q;
	logic [SEG_W:0]     tr_q;
	logic [2:0]         step_q;
	logic [1:0]         k_q;
	logic               c_q;
	logic               h_q;
	logic               out_valid_q;
	point_t             out_data_q;

	logic [COORD_W-1:0] pts_q [8];
	logic [W_W-1:0]     w_q [4];
	logic [SQ_W-1:0]    squ_q;
	logic [SQ_W-1:0]    sqt_q;
	logic [COORD_W-1:0] res_x_q;
	logic [COORD_W-1:0] res_y_q;

	logic               accept;
	logic               out_free;
	logic [SEG_W-1:0]   n_in;
	logic [SEG_W-1:0]   n_c;
	logic [15:0]        t_w;
	logic [16:0]        u_w;
	logic [1:0]         kmax;
	logic [2:0]         wlast;
	logic [SEG_W+1:0]   rem_sh;
	logic               div_ge;
	logic [SEG_W:0]     rem_next;
	logic [SEG_W+1:0]   tr_sum;
	logic               tr_ge;
	logic [SEG_W:0]     tr_next;
	logic [16:0]        tq_next;
	logic [W_W-1:0]     wsel;
	logic [COORD_W-1:0] psel;

	mac_op_t            op;
	logic [MA_W-1:0]    op_a;
	logic [MB_W-1:0]    op_b;
	wgt_wr_t            wgt_wr;
	res_wr_t            res_wr;

	assign curve.ready = state_q == ST_IDLE;
	assign accept      = curve.valid && curve.ready;
	assign out_free    = !out_valid_q || point.ready;
	assign point.valid = out_valid_q;
	assign point.data  = out_data_q;

	assign n_in = (curve.data.segments == '0) ? SEG_W'(1) : curve.data.segments;
	assign n_c  = (n_in > SEG_MAX) ? SEG_MAX : n_in;

	assign t_w   = tq_q[15:0];
	assign u_w   = 17'h10000 - {1'b0, t_w};
	assign kmax  = cubic_q ? 2'd3 : 2'd2;
	assign wlast = cubic_q ? 3'd5 : 3'd2;

	// restoring divide of 2^17 by 2n, one quotient bit a cycle
	assign rem_sh   = {rem_q, div_cnt_q == DIV_TOP};
	assign div_ge   = rem_sh >= {1'b0, d_q};
	assign rem_next = div_ge ? (SEG_W+1)'(rem_sh - {1'b0, d_q}) : rem_sh[SEG_W:0];

	// t advances by 2^17 / 2n with the remainder carried exactly
	assign tr_sum  = {1'b0, tr_q} + {1'b0, rem_q};
	assign tr_ge   = tr_sum >= {1'b0, d_q};
	assign tr_next = tr_ge ? (SEG_W+1)'(tr_sum - {1'b0, d_q}) : tr_sum[SEG_W:0];
	assign tq_next = tq_q + quo_q[16:0] + {16'b0, tr_ge};

	assign wsel = w_q[k_q];
	assign psel = pts_q[{k_q, c_q}];

	always_comb begin
		op       = '0;
		op.cubic = cubic_q;
		op_a     = '0;
		op_b     = '0;
		if (state_q == ST_WGT) begin
			op.valid = 1'b1;
			op.kind  = KIND_WGT;
			op.scale = SC_X1;
			if (cubic_q) begin
				case (step_q)
					3'd0: begin
						op_a = {16'b0, u_w}; op_b = u_w; op.dest = DST_SQU;
					end
					3'd1: begin
						op_a = {17'b0, t_w}; op_b = {1'b0, t_w}; op.dest = DST_SQT;
					end
					3'd2: begin
						op_a = squ_q; op_b = u_w; op.dest = DST_W0;
					end
					3'd3: begin
						op_a = squ_q; op_b = {1'b0, t_w}; op.dest = DST_W1; op.scale = SC_X3;
					end
					3'd4: begin
						op_a = sqt_q; op_b = u_w; op.dest = DST_W2; op.scale = SC_X3;
					end
					default: begin
						op_a = sqt_q; op_b = {1'b0, t_w}; op.dest = DST_W3;
					end
				endcase
			end else begin
				case (step_q)
					3'd0: begin
						op_a = {16'b0, u_w}; op_b = u_w; op.dest = DST_W0;
					end
					3'd1: begin
						op_a = {16'b0, u_w}; op_b = {1'b0, t_w}; op.dest = DST_W1;
						op.scale = SC_X2;
					end
					default: begin
						op_a = {17'b0, t_w}; op_b = {1'b0, t_w}; op.dest = DST_W2;
					end
				endcase
			end
		end else if (state_q == ST_ACC) begin
			op.valid = 1'b1;
			op.kind  = KIND_ACC;
			op.hi    = h_q;
			op.first = (k_q == 2'd0) && !h_q;
			op.last  = (k_q == kmax) && h_q;
			op.coord = c_q;
			op_a     = h_q ? {17'b0, wsel[W_W-1:HI_LSB]} : wsel[HI_LSB-1:0];
			op_b     = {1'b0, psel};
		end
	end

	bcf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.a      (op_a),
		.b      (op_b),
		.wgt_wr (wgt_wr),
		.res_wr (res_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cubic_q     <= 1'b0;
			n_q         <= '0;
			d_q         <= '0;
			idx_q       <= '0;
			div_cnt_q   <= '0;
			step_q      <= '0;
			k_q         <= '0;
			c_q         <= 1'b0;
			h_q         <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT || state_q == ST_LAST) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (point.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cubic_q   <= curve.data.curve_degree;
						n_q       <= n_c;
						d_q       <= {n_c, 1'b0};
						idx_q     <= '0;
						div_cnt_q <= DIV_TOP;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						step_q  <= '0;
						state_q <= ST_WGT;
					end else begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end
				end
				ST_WGT: begin
					if (step_q == wlast) begin
						k_q     <= '0;
						c_q     <= 1'b0;
						h_q     <= 1'b0;
						state_q <= ST_ACC;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_ACC: begin
					if (!h_q) begin
						h_q <= 1'b1;
					end else begin
						h_q <= 1'b0;
						if (k_q == kmax) begin
							k_q <= '0;
							if (c_q) begin
								state_q <= ST_DRAIN;
							end else begin
								c_q <= 1'b1;
							end
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				// last y product is still in the multiplier register
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (idx_q == n_q - SEG_W'(1)) begin
							state_q <= ST_LAST;
						end else begin
							idx_q   <= idx_q + SEG_W'(1);
							step_q  <= '0;
							state_q <= ST_WGT;
						end
					end
				end
				ST_LAST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pts_q[0] <= curve.data.start_x ^ BIAS;
			pts_q[1] <= curve.data.start_y ^ BIAS;
			pts_q[2] <= curve.data.ctrl1_x ^ BIAS;
			pts_q[3] <= curve.data.ctrl1_y ^ BIAS;
			// quadratic puts the end point in the third weight slot
			pts_q[4] <= (curve.data.curve_degree ? curve.data.ctrl2_x : curve.data.end_x) ^ BIAS;
			pts_q[5] <= (curve.data.curve_degree ? curve.data.ctrl2_y : curve.data.end_y) ^ BIAS;
			pts_q[6] <= curve.data.end_x ^ BIAS;
			pts_q[7] <= curve.data.end_y ^ BIAS;
			rem_q    <= '0;
			quo_q    <= '0;
			tq_q     <= '0;
			tr_q     <= {1'b0, n_c};
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[16:0], div_ge};
		end
		if (state_q == ST_EMIT && out_free) begin
			out_data_q.point_x    <= sat_coord(res_x_q);
			out_data_q.point_y    <= sat_coord(res_y_q);
			out_data_q.last_point <= 1'b0;
			tq_q                  <= tq_next;
			tr_q                  <= tr_next;
		end
		if (state_q == ST_LAST && out_free) begin
			out_data_q.point_x    <= sat_coord(pts_q[6]);
			out_data_q.point_y    <= sat_coord(pts_q[7]);
			out_data_q.last_point <= 1'b1;
		end
		if (wgt_wr.valid) begin
			if (wgt_wr.dest == DST_SQU) begin
				squ_q <= wgt_wr.value[SQ_W-1:0];
			end else if (wgt_wr.dest == DST_SQT) begin
				sqt_q <= wgt_wr.value[SQ_W-1:0];
			end else begin
				w_q[wgt_wr.dest[1:0]] <= wgt_wr.value;
			end
		end
		if (res_wr.valid) begin
			if (res_wr.coord) begin
				res_y_q <= res_wr.value;
			end else begin
				res_x_q <= res_wr.value;
			end
		end
	end

endmodule

`default_nettype wire
